// File: hw/rtl/ifns_pkg.sv
`timescale 1ns / 1ps

package ifns_pkg;

    localparam int PIXEL_W   = 32;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1080;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last_of_run;
        logic               end_of_frame;
    } result_t;

endpackage

// File: hw/rtl/inplace_four_neighbour_smoothing.sv
`timescale 1ns / 1ps

// In-place four-neighbour smoothing of a raster-order pixel stream.
// Input channel: in_valid / in_ready with pixel_in; a transfer takes one pixel.
// Output channel: out_valid / out_ready with pixel_out, last_of_run and
// end_of_frame; results run one row behind the input. Pixels of the first row
// give no result, pixels of the last row give two (row above, then itself).
// Configuration: cfg_write_enable, cfg_index, cfg_data; index 0 is the frame
// width, index 1 the frame height, both clamped to [3, MAX]. Write while idle.
// A result is written into the result queue on its input transfer and is offered from the queue head.
// Throughput: one pixel per cycle while the result queue has room, set by the four-term add of the left
// feedback path and the two read ports of the original row memory, which
// are addressed one pixel ahead; on the last row each pixel gives two results and the output takes one
// result per cycle, so the input slows there.
// A four-entry result queue parts the channels: input is taken while at least
// two entries are free, so a stalled receiver holds the input after three
// transfers, or after two on the last row.
// Reset clears the position counters and the queue and restores the sizes to
// 1920 by 1080; the row memories are not cleared and need no clearing pass.
module inplace_four_neighbour_smoothing
    import ifns_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_enable,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIXEL_W-1:0]   pixel_in,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIXEL_W-1:0]   pixel_out,
    output logic                 last_of_run,
    output logic                 end_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WCMP  = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int HCMP  = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;

    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [PIXEL_W-1:0] left_reg, left_next;

    logic [PIXEL_W-1:0] orig_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] upd_mem  [MAX_WIDTH];
    logic [PIXEL_W-1:0] orig_cur_reg;
    logic [PIXEL_W-1:0] orig_right_reg;
    logic [PIXEL_W-1:0] upd_cur_reg;
    logic [CW-1:0]      rd_addr;
    logic [CW-1:0]      rd_addr_right;

    result_t            oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] head_reg, head_next;
    logic [OQ_PTR_W-1:0] tail_reg, tail_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;

    logic [WCMP-1:0]    w_ext, w_use, w_last;
    logic [HCMP-1:0]    h_ext, h_use, h_last;
    logic               last_col;
    logic               last_row;
    logic               interior;
    logic               in_fire;
    logic               pop;
    logic [1:0]         push_n;
    logic [PIXEL_W+1:0] sum;
    logic [PIXEL_W-1:0] val;
    logic [PIXEL_W-1:0] upd_wdata;
    result_t            res0, res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_ext = WCMP'(frame_width_reg);
        if (w_ext < WCMP'(3))
            w_use = WCMP'(3);
        else if (w_ext > WCMP'(MAX_WIDTH))
            w_use = WCMP'(MAX_WIDTH);
        else
            w_use = w_ext;
        w_last = w_use - WCMP'(1);

        h_ext = HCMP'(frame_height_reg);
        if (h_ext < HCMP'(3))
            h_use = HCMP'(3);
        else if (h_ext > HCMP'(MAX_HEIGHT))
            h_use = HCMP'(MAX_HEIGHT);
        else
            h_use = h_ext;
        h_last = h_use - HCMP'(1);
    end

    assign last_col = (WCMP'(col_reg) >= w_last);
    assign last_row = (HCMP'(row_reg) >= h_last);
    assign interior = (row_reg != RW'(1)) && (col_reg != '0) && !last_col;

    assign in_ready = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign in_fire  = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    assign sum = {2'b00, left_reg} + {2'b00, orig_right_reg}
               + {2'b00, upd_cur_reg} + {2'b00, pixel_in};
    assign val = interior ? sum[PIXEL_W+1:2] : orig_cur_reg;
    assign upd_wdata = (row_reg == '0) ? pixel_in : val;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (in_fire)
        begin
            if (row_reg != '0)
                left_next = val;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // read one pixel ahead so the data is ready for the next transfer
    assign rd_addr       = col_next;
    assign rd_addr_right = (col_next == CW'(MAX_WIDTH - 1)) ? '0 : col_next + CW'(1);

    always_ff @(posedge clk)
    begin
        orig_cur_reg   <= orig_mem[rd_addr];
        orig_right_reg <= orig_mem[rd_addr_right];
        upd_cur_reg    <= upd_mem[rd_addr];
        if (in_fire)
        begin
            orig_mem[col_reg] <= pixel_in;
            upd_mem[col_reg]  <= upd_wdata;
        end
    end

    always_comb
    begin
        res0.pixel        = val;
        res0.last_of_run  = !last_row;
        res0.end_of_frame = 1'b0;
        res1.pixel        = pixel_in;
        res1.last_of_run  = 1'b1;
        res1.end_of_frame = last_col;

        if (!in_fire || row_reg == '0)
            push_n = 2'd0;
        else if (last_row)
            push_n = 2'd2;
        else
            push_n = 2'd1;

        tail_next  = tail_reg + OQ_PTR_W'(push_n);
        head_next  = pop ? head_reg + OQ_PTR_W'(1) : head_reg;
        count_next = count_reg + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            oq_mem[tail_reg] <= res0;
        if (push_n == 2'd2)
            oq_mem[tail_reg + OQ_PTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign out_valid    = (count_reg != '0);
    assign pixel_out    = oq_mem[head_reg].pixel;
    assign last_of_run  = oq_mem[head_reg].last_of_run;
    assign end_of_frame = oq_mem[head_reg].end_of_frame;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < MAX_WIDTH) && (32'(row_reg) < MAX_HEIGHT))
        else $error("position counter out of range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_col && last_row |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not wrap");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("end of frame without last of run");

endmodule

// File: dv/tb_inplace_four_neighbour_smoothing.sv
`timescale 1ns / 1ps

import ifns_pkg::*;

class smoothing_scoreboard;

    localparam int MAX_W = 2048;
    localparam int MAX_H = 2048;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [PIXEL_W-1:0] orig_line [MAX_W];
    logic [PIXEL_W-1:0] upd_line [MAX_W];
    logic [PIXEL_W-1:0] left_val;
    int unsigned        row_pos;
    int unsigned        col_pos;
    result_t            smoothed_due [$];
    int unsigned        errors;
    int unsigned        pixels_taken;
    int unsigned        results_seen;
    int unsigned        frames_seen;

    function new();
        width_reg    = FRAME_WIDTH_RST;
        height_reg   = FRAME_HEIGHT_RST;
        left_val     = '0;
        row_pos      = 0;
        col_pos      = 0;
        errors       = 0;
        pixels_taken = 0;
        results_seen = 0;
        frames_seen  = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3)
        begin
            return 3;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function int unsigned cur_width();
        return clamp_dim(width_reg, MAX_W);
    endfunction

    function int unsigned cur_height();
        return clamp_dim(height_reg, MAX_H);
    endfunction

    function bit at_frame_start();
        return row_pos == 0 && col_pos == 0;
    endfunction

    function int unsigned pending();
        return smoothed_due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:  width_reg = val;
            REG_FRAME_HEIGHT: height_reg = val;
            default: ;
        endcase
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] pix);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        bit                 last_col;
        bit                 last_row;
        logic [PIXEL_W-1:0] val;
        logic [PIXEL_W+1:0] sum;
        result_t            res;
        w = cur_width();
        h = cur_height();
        c = col_pos % MAX_W;
        r = row_pos;
        last_col = c >= w - 1;
        last_row = r >= h - 1;
        pixels_taken++;
        if (r == 0)
        begin
            orig_line[c] = pix;
            upd_line[c]  = pix;
        end
        else
        begin
            if (r == 1 || c == 0 || last_col)
            begin
                val = orig_line[c];
            end
            else
            begin
                sum = {2'b00, left_val} + orig_line[(c + 1) % MAX_W] + upd_line[c] + pix;
                val = sum[PIXEL_W+1:2];
            end
            left_val     = val;
            upd_line[c]  = val;
            orig_line[c] = pix;
            res.pixel        = val;
            res.last_of_run  = !last_row;
            res.end_of_frame = 1'b0;
            smoothed_due.push_back(res);
            if (last_row)
            begin
                res.pixel        = pix;
                res.last_of_run  = 1'b1;
                res.end_of_frame = last_col;
                smoothed_due.push_back(res);
            end
        end
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
            if (last_row)
            begin
                frames_seen++;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    function void check_result(logic [PIXEL_W-1:0] pix, logic lor, logic eof);
        result_t want;
        results_seen++;
        if (smoothed_due.size() == 0)
        begin
            $display("%0t: unexpected transfer, expected none, actual pixel_out %h lor %b eof %b",
                     $time, pix, lor, eof);
            errors++;
            return;
        end
        want = smoothed_due.pop_front();
        if (want.pixel !== pix)
        begin
            $display("%0t: pixel_out mismatch, expected %h, actual %h", $time, want.pixel, pix);
            errors++;
        end
        if (want.last_of_run !== lor)
        begin
            $display("%0t: last_of_run mismatch, expected %b, actual %b",
                     $time, want.last_of_run, lor);
            errors++;
        end
        if (want.end_of_frame !== eof)
        begin
            $display("%0t: end_of_frame mismatch, expected %b, actual %b",
                     $time, want.end_of_frame, eof);
            errors++;
        end
    endfunction

endclass

module tb_inplace_four_neighbour_smoothing;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int     RANDOM_PIXELS = 1600;
    localparam int     HOLD_CYCLES   = 300;
    localparam longint LIMIT_NS      = 40_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_enable;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [PIXEL_W-1:0]   pixel_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIXEL_W-1:0]   pixel_out;
    logic                 last_of_run;
    logic                 end_of_frame;

    bit          send_steady  = 1'b0;
    bit          take_steady  = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned holds_done   = 0;
    int unsigned resizes      = 0;

    smoothing_scoreboard sb = new();

    inplace_four_neighbour_smoothing dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pixel_in         (pixel_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pixel_out        (pixel_out),
        .last_of_run      (last_of_run),
        .end_of_frame     (end_of_frame)
    );

    always #10 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                             input bit spares);
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        if (spares)
        begin
            write_reg(REG_SPARE_A, '1);
            write_reg(REG_SPARE_B, CFG_W'($urandom));
        end
        cfg_write_enable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(pix);
    endtask

    // drop valid, drain, then give the block time to finish rows that yield nothing
    task automatic settle(input int cycles);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel(input bit harsh);
        if (!harsh)
        begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic drive_frame(input bit harsh, input bit resize_midway);
        int unsigned area;
        int unsigned cut;
        int unsigned k;
        area = sb.cur_width() * sb.cur_height();
        cut  = resize_midway ? $urandom_range(1, area - 1) : area;
        for (k = 0; k < cut; k++)
        begin
            send_pixel(pick_pixel(harsh));
        end
        if (resize_midway)
        begin
            settle(4);
            // width never grows, so every store entry read has been written this frame
            set_frame(CFG_W'($urandom_range(0, sb.cur_width())),
                      CFG_W'($urandom_range(0, 12)), 1'b0);
            resizes++;
            while (!sb.at_frame_start())
            begin
                send_pixel(pick_pixel(harsh));
            end
        end
    endtask

    initial
    begin : take_results
        int stall;
        out_ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = take_steady ? 0 : $urandom_range(0, 4);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(pixel_out, last_of_run, end_of_frame);
        end
    end

    initial
    begin : stimulus
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned k;
        int unsigned start;
        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        pixel_in         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame from sizes below range, alternating extremes
        set_frame(12'd0, 12'd2, 1'b1);
        for (k = 0; k < 9; k++)
        begin
            send_pixel(k[0] ? '0 : '1);
        end
        settle(4);
        // full-scale sum on every interior pixel
        set_frame(12'd4, 12'd3, 1'b0);
        repeat (12) send_pixel('1);

        start = sb.pixels_taken;
        while (sb.pixels_taken - start < RANDOM_PIXELS)
        begin
            settle(4);
            send_steady = ($urandom_range(0, 4) == 0);
            take_steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 19))
                0:          w_raw = $urandom_range(0, 2);
                1, 2, 3, 4: w_raw = $urandom_range(11, 40);
                default:    w_raw = $urandom_range(3, 10);
            endcase
            h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_frame(CFG_W'(w_raw), CFG_W'(h_raw), $urandom_range(0, 9) == 0);
            if (sb.cur_width() * sb.cur_height() >= 80 && holds_done < 3
                && $urandom_range(0, 2) == 0)
            begin
                hold_off_req = 1'b1;
                holds_done++;
            end
            drive_frame($urandom_range(0, 1) == 1, $urandom_range(0, 6) == 0);
        end

        // clamped widest and tallest sizes on a short first row, then shrink
        // and finish the frame under a long output hold
        settle(4);
        set_frame('1, '1, 1'b0);
        hold_off_req = 1'b1;
        holds_done++;
        repeat (40) send_pixel(pick_pixel(1'b1));
        settle(4);
        set_frame(12'd6, 12'd3, 1'b0);
        resizes++;
        while (!sb.at_frame_start())
        begin
            send_pixel(pick_pixel(1'b0));
        end

        settle(20);
        $display("Run: %0d pixels in %0d frames, %0d results checked",
                 sb.pixels_taken, sb.frames_seen, sb.results_seen);
        $display("Run: %0d mid-frame resizes, %0d long output holds, sizes 3 to 2048",
                 resizes, holds_done);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
